// ----- rtl/assert_macros.svh -----
// Assertion macros for the centroid RTL, included by bic_back.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, property given whole
`define BIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define BIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bic_pkg.sv -----
// Package for the binary image centroid block: sizes, frame record type, back-end states.
// No dependencies.
package bic_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int CFG_W  = 11;
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 10;
  localparam int SUM_W  = 30;
  localparam int CNT_W  = 21;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(1024);

  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] col_sum;
    logic [CNT_W-1:0] count;
  } frame_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

// ----- rtl/bic_front.sv -----
// Front end: holds the column count, tracks raster position and accumulates frame sums.
// Uses bic_pkg; pushes one frame record into the queue on each last pixel.
module bic_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bic_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bic_pkg::PIX_W-1:0]     in_pixel_value,
  input  logic                          in_last_pixel,
  input  logic                          q_full,
  output logic                          q_push,
  output bic_pkg::frame_t               q_wdata
);

  logic [bic_pkg::CFG_W-1:0] image_cols_r;
  logic [bic_pkg::COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [bic_pkg::ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [bic_pkg::SUM_W-1:0] row_sum_r, row_sum_nxt;
  logic [bic_pkg::SUM_W-1:0] col_sum_r, col_sum_nxt;
  logic [bic_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [bic_pkg::COL_W:0]   cols_eff;
  logic [bic_pkg::COL_W:0]   col_inc;
  logic [bic_pkg::ROW_W:0]   row_inc;
  logic [bic_pkg::SUM_W:0]   row_add, col_add;
  logic [bic_pkg::SUM_W-1:0] row_sum_upd, col_sum_upd;
  logic [bic_pkg::CNT_W-1:0] cnt_upd;
  logic                      accept, lit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign lit      = in_pixel_value != '0;

  always_comb begin
    if (image_cols_r == '0) begin
      cols_eff = (bic_pkg::COL_W+1)'(1);
    end else if (int'(image_cols_r) > bic_pkg::MAX_COLS) begin
      cols_eff = (bic_pkg::COL_W+1)'(bic_pkg::MAX_COLS);
    end else begin
      cols_eff = (bic_pkg::COL_W+1)'(image_cols_r);
    end
  end

  always_comb begin
    row_add = {1'b0, row_sum_r} + (bic_pkg::SUM_W+1)'(row_pos_r);
    col_add = {1'b0, col_sum_r} + (bic_pkg::SUM_W+1)'(col_pos_r);
    row_sum_upd = row_sum_r;
    col_sum_upd = col_sum_r;
    cnt_upd     = cnt_r;
    if (lit) begin
      row_sum_upd = row_add[bic_pkg::SUM_W] ? bic_pkg::SUM_MAX : row_add[bic_pkg::SUM_W-1:0];
      col_sum_upd = col_add[bic_pkg::SUM_W] ? bic_pkg::SUM_MAX : col_add[bic_pkg::SUM_W-1:0];
      cnt_upd     = (cnt_r == bic_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    end
  end

  always_comb begin
    col_inc     = {1'b0, col_pos_r} + 1'b1;
    row_inc     = {1'b0, row_pos_r} + 1'b1;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    row_sum_nxt = row_sum_r;
    col_sum_nxt = col_sum_r;
    cnt_nxt     = cnt_r;
    q_push      = 1'b0;
    q_wdata.row_sum = row_sum_upd;
    q_wdata.col_sum = col_sum_upd;
    q_wdata.count   = cnt_upd;
    if (accept) begin
      if (in_last_pixel) begin
        q_push      = 1'b1;
        col_pos_nxt = '0;
        row_pos_nxt = '0;
        row_sum_nxt = '0;
        col_sum_nxt = '0;
        cnt_nxt     = '0;
      end else begin
        row_sum_nxt = row_sum_upd;
        col_sum_nxt = col_sum_upd;
        cnt_nxt     = cnt_upd;
        if (col_inc >= cols_eff) begin
          col_pos_nxt = '0;
          if (row_inc >= (bic_pkg::ROW_W+1)'(bic_pkg::MAX_ROWS)) begin
            row_pos_nxt = '0;
          end else begin
            row_pos_nxt = row_inc[bic_pkg::ROW_W-1:0];
          end
        end else begin
          col_pos_nxt = col_inc[bic_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_cols_r <= bic_pkg::COLS_RESET;
      col_pos_r    <= '0;
      row_pos_r    <= '0;
      row_sum_r    <= '0;
      col_sum_r    <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        image_cols_r <= cfg_wr_data;
      end
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      row_sum_r <= row_sum_nxt;
      col_sum_r <= col_sum_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/bic_queue.sv -----
// Two-entry queue of frame records between the front end and the divider.
// Uses bic_pkg for the record type and depth.
module bic_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bic_pkg::frame_t wdata,
  input  logic            pop,
  output bic_pkg::frame_t rdata,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (bic_pkg::Q_DEPTH > 1) ? $clog2(bic_pkg::Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(bic_pkg::Q_DEPTH + 1);

  bic_pkg::frame_t    slot_r [bic_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0]  fill_r;
  logic               do_push, do_pop;

  assign full    = fill_r == FILL_W'(bic_pkg::Q_DEPTH);
  assign empty   = fill_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(bic_pkg::Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(bic_pkg::Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bic_back.sv -----
// Back end: bit-serial division of both sums by the lit count, then the output register.
// Uses bic_pkg and assert_macros.svh; pops one frame record per result word.
`include "assert_macros.svh"

module bic_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  bic_pkg::frame_t             q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bic_pkg::IDX_W-1:0]   out_center_row,
  output logic [bic_pkg::IDX_W-1:0]   out_center_col,
  output logic                        out_empty_image,
  output logic [bic_pkg::CNT_W-1:0]   out_lit_count
);

  bic_pkg::back_state_t state_r, state_nxt;

  logic [bic_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [bic_pkg::SUM_W-1:0]  dvd_row_r, dvd_row_nxt;
  logic [bic_pkg::SUM_W-1:0]  dvd_col_r, dvd_col_nxt;
  logic [bic_pkg::CNT_W-1:0]  rem_row_r, rem_row_nxt;
  logic [bic_pkg::CNT_W-1:0]  rem_col_r, rem_col_nxt;
  logic [bic_pkg::CNT_W-1:0]  div_r, div_nxt;
  logic                       empty_r, empty_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [bic_pkg::IDX_W-1:0]  out_row_r, out_row_nxt;
  logic [bic_pkg::IDX_W-1:0]  out_col_r, out_col_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic [bic_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [bic_pkg::CNT_W:0]    trial_row, trial_col;
  logic                       ge_row, ge_col;
  logic                       out_free;

  assign out_free = !out_valid_r || !out_stall;

  assign trial_row = {rem_row_r, dvd_row_r[bic_pkg::SUM_W-1]};
  assign trial_col = {rem_col_r, dvd_col_r[bic_pkg::SUM_W-1]};
  assign ge_row    = trial_row >= {1'b0, div_r};
  assign ge_col    = trial_col >= {1'b0, div_r};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    dvd_row_nxt   = dvd_row_r;
    dvd_col_nxt   = dvd_col_r;
    rem_row_nxt   = rem_row_r;
    rem_col_nxt   = rem_col_r;
    div_nxt       = div_r;
    empty_nxt     = empty_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_empty_nxt = out_empty_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      bic_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          div_nxt     = q_rdata.count;
          rem_row_nxt = '0;
          rem_col_nxt = '0;
          step_nxt    = '0;
          if (q_rdata.count == '0) begin
            empty_nxt   = 1'b1;
            dvd_row_nxt = '0;
            dvd_col_nxt = '0;
            state_nxt   = bic_pkg::BK_HOLD;
          end else begin
            empty_nxt   = 1'b0;
            dvd_row_nxt = q_rdata.row_sum;
            dvd_col_nxt = q_rdata.col_sum;
            state_nxt   = bic_pkg::BK_DIV;
          end
        end
      end
      bic_pkg::BK_DIV: begin
        rem_row_nxt = ge_row ? bic_pkg::CNT_W'(trial_row - {1'b0, div_r})
                             : trial_row[bic_pkg::CNT_W-1:0];
        rem_col_nxt = ge_col ? bic_pkg::CNT_W'(trial_col - {1'b0, div_r})
                             : trial_col[bic_pkg::CNT_W-1:0];
        dvd_row_nxt = {dvd_row_r[bic_pkg::SUM_W-2:0], ge_row};
        dvd_col_nxt = {dvd_col_r[bic_pkg::SUM_W-2:0], ge_col};
        step_nxt    = step_r + 1'b1;
        if (step_r == bic_pkg::STEP_W'(bic_pkg::DIV_STEPS-1)) begin
          state_nxt = bic_pkg::BK_HOLD;
        end
      end
      bic_pkg::BK_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = (dvd_row_r > bic_pkg::SUM_W'(bic_pkg::MAX_ROWS-1))
                          ? bic_pkg::IDX_W'(bic_pkg::MAX_ROWS-1)
                          : dvd_row_r[bic_pkg::IDX_W-1:0];
          out_col_nxt   = (dvd_col_r > bic_pkg::SUM_W'(bic_pkg::MAX_COLS-1))
                          ? bic_pkg::IDX_W'(bic_pkg::MAX_COLS-1)
                          : dvd_col_r[bic_pkg::IDX_W-1:0];
          out_empty_nxt = empty_r;
          out_cnt_nxt   = div_r;
          state_nxt     = bic_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = bic_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bic_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    dvd_row_r   <= dvd_row_nxt;
    dvd_col_r   <= dvd_col_nxt;
    rem_row_r   <= rem_row_nxt;
    rem_col_r   <= rem_col_nxt;
    div_r       <= div_nxt;
    empty_r     <= empty_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_empty_r <= out_empty_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_center_row  = out_row_r;
  assign out_center_col  = out_col_r;
  assign out_empty_image = out_empty_r;
  assign out_lit_count   = out_cnt_r;

  `BIC_ASSERT(a_rem_below_div, ((state_r == bic_pkg::BK_DIV) |-> (rem_row_r < div_r && rem_col_r < div_r)), "remainder not below divisor")
  `BIC_ASSERT(a_pop_when_idle, (q_pop |-> (state_r == bic_pkg::BK_IDLE && !q_empty)), "pop outside idle or from empty queue")
  `BIC_ASSERT(a_empty_zero, ((out_valid_r && out_empty_r) |-> (out_row_r == '0 && out_col_r == '0 && out_cnt_r == '0)), "empty frame with nonzero fields")
  `BIC_ASSERT(a_lit_nonzero, ((out_valid_r && !out_empty_r) |-> (out_cnt_r != '0)), "lit frame with zero count")
  `BIC_ASSERT_NEXT(a_div_ends, state_r == bic_pkg::BK_DIV && step_r == bic_pkg::STEP_W'(bic_pkg::DIV_STEPS-1), state_r == bic_pkg::BK_HOLD, "divider did not finish")

endmodule

// ----- rtl/binary_image_centroid.sv -----
// Top level of the binary image centroid block: front end, frame queue, divider back end.
// Uses bic_pkg, bic_front, bic_queue and bic_back.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_stall   | pixel_value, last_pixel
//   out_    | output    | out_valid / out_stall | center_row, center_col, empty_image, lit_count
//   cfg_    | input     | cfg_wr_en             | image_cols
//
// Pixels are taken one per cycle; in_stall rises only when both queue slots hold frames.
// The back end runs a bit-serial divide of both sums for each frame (skipped for a frame with no
// lit pixels), overlapping the next frame's pixels.
// Synchronous active-low reset clears positions, sums, queue and output valid.
// A stalled result word holds in the output register while the divider works on the next frame.
module binary_image_centroid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bic_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bic_pkg::PIX_W-1:0]   in_pixel_value,
  input  logic                        in_last_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bic_pkg::IDX_W-1:0]   out_center_row,
  output logic [bic_pkg::IDX_W-1:0]   out_center_col,
  output logic                        out_empty_image,
  output logic [bic_pkg::CNT_W-1:0]   out_lit_count
);

  logic            q_push, q_pop, q_full, q_empty;
  bic_pkg::frame_t q_wdata, q_rdata;

  bic_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .in_last_pixel  (in_last_pixel),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  bic_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  bic_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_center_row  (out_center_row),
    .out_center_col  (out_center_col),
    .out_empty_image (out_empty_image),
    .out_lit_count   (out_lit_count)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for binary_image_centroid: raster frames and column settings under
// varied flow control, each centroid word scored against an in-bench predictor.
// Depends on bic_pkg and the binary_image_centroid RTL.
module testbench;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 800;

  typedef struct packed {
    logic [bic_pkg::IDX_W-1:0] row;
    logic [bic_pkg::IDX_W-1:0] col;
    logic                      empty;
    logic [bic_pkg::CNT_W-1:0] count;
  } centroid_t;

  typedef enum int {FILL_DARK, FILL_BRIGHT, FILL_HALF, FILL_SPARSE} fill_t;

  class centroid_scoreboard;
    logic [bic_pkg::CFG_W-1:0] cols_reg;
    logic [bic_pkg::IDX_W-1:0] col_pos;
    logic [bic_pkg::IDX_W-1:0] row_pos;
    logic [bic_pkg::SUM_W-1:0] row_sum;
    logic [bic_pkg::SUM_W-1:0] col_sum;
    logic [bic_pkg::CNT_W-1:0] lit_cnt;
    centroid_t                 centroid_q[$];
    int                        errors;

    function new();
      cols_reg = bic_pkg::COLS_RESET;
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      col_pos = '0;
      row_pos = '0;
      row_sum = '0;
      col_sum = '0;
      lit_cnt = '0;
    endfunction

    function void set_cols(logic [bic_pkg::CFG_W-1:0] v);
      cols_reg = v;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                      longint unsigned lim);
      return (a + b > lim) ? lim : a + b;
    endfunction

    function void take_pixel(logic [bic_pkg::PIX_W-1:0] pix, logic last);
      int unsigned     cols;
      longint unsigned q;
      centroid_t       c;
      cols = cols_reg;
      if (cols == 0) cols = 1;
      if (cols > bic_pkg::MAX_COLS) cols = bic_pkg::MAX_COLS;
      if (pix != 0) begin
        row_sum = bic_pkg::SUM_W'(sat_add(row_sum, row_pos, bic_pkg::SUM_MAX));
        col_sum = bic_pkg::SUM_W'(sat_add(col_sum, col_pos, bic_pkg::SUM_MAX));
        lit_cnt = bic_pkg::CNT_W'(sat_add(lit_cnt, 1, bic_pkg::CNT_MAX));
      end
      if (!last) begin
        if (int'(col_pos) + 1 >= cols) begin
          col_pos = '0;
          row_pos = (int'(row_pos) + 1 >= bic_pkg::MAX_ROWS) ? '0 : row_pos + 1'b1;
        end else begin
          col_pos = col_pos + 1'b1;
        end
        return;
      end
      c = '0;
      if (lit_cnt == 0) begin
        c.empty = 1'b1;
      end else begin
        q = row_sum / lit_cnt;
        c.row = (q > bic_pkg::MAX_ROWS - 1) ? bic_pkg::IDX_W'(bic_pkg::MAX_ROWS - 1)
                                             : bic_pkg::IDX_W'(q);
        q = col_sum / lit_cnt;
        c.col = (q > bic_pkg::MAX_COLS - 1) ? bic_pkg::IDX_W'(bic_pkg::MAX_COLS - 1)
                                             : bic_pkg::IDX_W'(q);
        c.count = lit_cnt;
      end
      centroid_q = {centroid_q, c};
      clear_frame();
    endfunction

    function void match_centroid(centroid_t got);
      centroid_t want;
      if (centroid_q.size() == 0) begin
        $error("unexpected centroid word: row %0d col %0d empty %0b count %0d",
               got.row, got.col, got.empty, got.count);
        errors++;
        return;
      end
      want = centroid_q.pop_front();
      if (got.row !== want.row) begin
        $error("center_row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("center_col: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("empty_image: expected %0b, got %0b", want.empty, got.empty);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("lit_count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [bic_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [bic_pkg::PIX_W-1:0] in_pixel_value = '0;
  logic                      in_last_pixel = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [bic_pkg::IDX_W-1:0] out_center_row;
  logic [bic_pkg::IDX_W-1:0] out_center_col;
  logic                      out_empty_image;
  logic [bic_pkg::CNT_W-1:0] out_lit_count;

  centroid_scoreboard board = new();
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int idle_cycles = 0;

  binary_image_centroid dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_center_row  (out_center_row),
    .out_center_col  (out_center_col),
    .out_empty_image (out_empty_image),
    .out_lit_count   (out_lit_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.take_pixel(in_pixel_value, in_last_pixel);
      end
      if (out_valid && !out_stall) begin
        board.match_centroid({out_center_row, out_center_col, out_empty_image,
                              out_lit_count});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [bic_pkg::PIX_W-1:0] pix, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    in_last_pixel  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.centroid_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cols(logic [bic_pkg::CFG_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_cols(v);
  endtask

  task automatic send_frame(int len, fill_t fill, bit close);
    logic lit;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_DARK:   lit = 1'b0;
        FILL_BRIGHT: lit = 1'b1;
        FILL_HALF:   lit = 1'($urandom_range(1));
        default:     lit = ($urandom_range(9) == 0);
      endcase
      send_pixel(lit ? bic_pkg::PIX_W'($urandom_range(1, 255)) : '0,
                 close && (i == len - 1));
    end
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int sent;
    int len;
    bit close;
    idle_by_phase  = '{0, 88, 0, 21};
    stall_by_phase = '{0, 0, 88, 21};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset column count, extremes of pixel value, empty and single-pixel frames
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);

    // zero columns act as one column per row
    write_cols('0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b1);

    write_cols(bic_pkg::CFG_W'(3));
    send_frame(7, FILL_BRIGHT, 1'b1);

    // above the maximum acts as the maximum
    write_cols('1);
    send_frame(2, FILL_BRIGHT, 1'b1);

    // shrink the row while the column position is already past the new end
    write_cols(bic_pkg::CFG_W'(4));
    send_frame(3, FILL_BRIGHT, 1'b0);
    write_cols(bic_pkg::CFG_W'(2));
    send_frame(3, FILL_BRIGHT, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_cols(bic_pkg::CFG_W'($urandom_range(2, 16)));
        1:       write_cols(bic_pkg::CFG_W'(1));
        2:       write_cols(bic_pkg::CFG_W'(1025));
        default: write_cols(bic_pkg::CFG_W'($urandom_range(0, 2047)));
      endcase
      send_idle_pct = idle_by_phase[p];
      out_stall_pct = stall_by_phase[p];
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        close = (sent + len < RANDOM_ITEMS / 4) || ($urandom_range(1) == 1);
        send_frame(len, fill_t'($urandom_range(3)), close);
        sent += len;
        if ($urandom_range(9) == 0) drain();
      end
    end

    send_idle_pct = 0;
    out_stall_pct = 0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.centroid_q.size() != 0) begin
      $error("%0d centroid words never arrived", board.centroid_q.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bic_pkg.sv
rtl/bic_front.sv
rtl/bic_queue.sv
rtl/bic_back.sv
rtl/binary_image_centroid.sv
bench/testbench.sv
